[hdl/rmv_pkg.sv]
// Shared types and constants for the running mean and variance block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package rmv_pkg;

	// Number of count bits; the count may reach 2**COUNT_BITS.
	localparam int COUNT_BITS = 20;

	// Field and accumulator widths.
	localparam int SAMPLE_W = 16;
	localparam int CNT_W    = COUNT_BITS + 1;
	localparam int SUM_W    = SAMPLE_W + COUNT_BITS + 1;
	localparam int MAG_W    = SUM_W - 1;
	localparam int SQ_W     = 2 * SAMPLE_W - 2 + COUNT_BITS + 1;
	localparam int PROD_W   = CNT_W + SQ_W;
	localparam int DIVR_W   = 2 * CNT_W;
	localparam int REM_W    = DIVR_W + 1;
	localparam int VAR_W    = 31;
	localparam int ROOT_W   = VAR_W + 1;
	localparam int RES_W    = 16;
	localparam int SQRT_STEPS = (VAR_W + 1) / 2;
	localparam int ITER_W   = $clog2(MAG_W + 1);

	localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

	// Input item.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       restart;
	} in_item_t;

	// Result item.
	typedef struct packed {
		logic [CNT_W-1:0]           count;
		logic signed [SAMPLE_W-1:0] mean;
		logic [VAR_W-1:0]           variance;
		logic [RES_W-1:0]           std_dev;
		logic [RES_W-1:0]           std_err_mean;
		logic                       variance_invalid;
		logic                       overflow;
	} out_item_t;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_UPDATE,
		OP_MULA_LD,
		OP_MULB_LD,
		OP_MUL_STEP,
		OP_DIFF,
		OP_VDIV_LD,
		OP_MDIV_LD,
		OP_SEDIV_LD,
		OP_DIV_STEP,
		OP_SQ1_LD,
		OP_SQ2_LD,
		OP_SQRT_STEP,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic last;
	} status_t;

endpackage

[hdl/rmv_if.sv]
// Channel interfaces for the running mean and variance block.
// Depends on rmv_pkg for the item types.
`timescale 1ns / 1ps

// Sample channel.
interface rmv_in_if import rmv_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Result channel.
interface rmv_out_if import rmv_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel for the Bessel mode register.
interface rmv_cfg_if ();
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/rmv_dp.sv]
// Datapath: accumulators, shift-add multiplier, restoring divider and square root unit.
// Depends on rmv_pkg and rmv_if; driven by rmv_ctrl through cmd_t.
`timescale 1ns / 1ps

module rmv_dp import rmv_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cmd_t            cmd,
	output status_t         status,
	input  in_item_t        in_item,
	rmv_cfg_if.sink         cfg,
	output out_item_t       result
);

	logic                      bessel_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [SQ_W-1:0]           sq_q;
	logic                      ovf_q;
	logic [ITER_W-1:0]         iter_q;

	logic [PROD_W-1:0]         acc_q;
	logic [PROD_W-1:0]         mcand_q;
	logic [MAG_W-1:0]          mlr_q;
	logic [PROD_W-1:0]         a_q;
	logic [PROD_W-1:0]         diff_q;
	logic [DIVR_W-1:0]         divisor_q;
	logic [REM_W-1:0]          rem_q;
	logic [PROD_W-1:0]         dvd_q;
	logic                      sat_q;
	logic [VAR_W-1:0]          var_q;
	logic signed [SAMPLE_W-1:0] mean_q;
	logic [VAR_W-1:0]          se_arg_q;
	logic [RES_W-1:0]          sd_q;
	logic [VAR_W-1:0]          rad_q;
	logic [ROOT_W-1:0]         root_q;
	logic [VAR_W-1:0]          bit_q;

	logic [CNT_W-1:0]          cnt_base;
	logic signed [SUM_W-1:0]   sum_base;
	logic [SQ_W-1:0]           sq_base;
	logic signed [2*SAMPLE_W-1:0] sample_sq;
	logic signed [SUM_W-1:0]   sum_abs;
	logic [MAG_W-1:0]          mag;
	logic [CNT_W-1:0]          n_sel;
	logic [DIVR_W-1:0]         n_prod;
	logic [REM_W-1:0]          rem_sh;
	logic                      q_bit;
	logic [SAMPLE_W-1:0]       quot_lo;
	logic [ROOT_W-1:0]         trial;
	logic                      invalid;

	assign cfg.ready = 1'b1;
	assign status.last = (iter_q == ITER_W'(1));

	// Restart clears the state before the sample is added.
	always_comb begin
		cnt_base  = in_item.restart ? '0 : cnt_q;
		sum_base  = in_item.restart ? '0 : sum_q;
		sq_base   = in_item.restart ? '0 : sq_q;
		sample_sq = in_item.sample * in_item.sample;
	end

	// Magnitude of the sum and the variance divisor.
	always_comb begin
		sum_abs   = sum_q[SUM_W-1] ? -sum_q : sum_q;
		mag       = sum_abs[MAG_W-1:0];
		n_sel     = bessel_q ? (cnt_q - CNT_W'(1)) : cnt_q;
		n_prod    = DIVR_W'(cnt_q) * DIVR_W'(n_sel);
	end

	// One restoring division step.
	always_comb begin
		rem_sh = {rem_q[REM_W-2:0], dvd_q[PROD_W-1]};
		q_bit  = (rem_sh >= REM_W'(divisor_q));
	end

	// Quotient of the mean division and one square root step.
	always_comb begin
		quot_lo = dvd_q[SAMPLE_W-1:0];
		trial   = root_q + ROOT_W'(bit_q);
		invalid = bessel_q && (cnt_q == CNT_W'(1));
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bessel_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			bessel_q <= cfg.data;
		end
	end

	// Accumulator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			sq_q  <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.op == OP_UPDATE) begin
			if (cnt_base[CNT_W-1]) begin
				// Full count: the sample is dropped.
				ovf_q <= 1'b1;
				cnt_q <= cnt_base;
				sum_q <= sum_base;
				sq_q  <= sq_base;
			end else begin
				ovf_q <= 1'b0;
				cnt_q <= cnt_base + CNT_W'(1);
				sum_q <= sum_base + SUM_W'(in_item.sample);
				sq_q  <= sq_base + SQ_W'(sample_sq[2*SAMPLE_W-2:0]);
			end
		end
	end

	// Iteration counter shared by all multi-cycle units.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else begin
			case (cmd.op)
				OP_MULA_LD:                        iter_q <= ITER_W'(CNT_W);
				OP_MULB_LD, OP_MDIV_LD:            iter_q <= ITER_W'(MAG_W);
				OP_VDIV_LD, OP_SEDIV_LD:           iter_q <= ITER_W'(VAR_W);
				OP_SQ1_LD, OP_SQ2_LD:              iter_q <= ITER_W'(SQRT_STEPS);
				OP_MUL_STEP, OP_DIV_STEP, OP_SQRT_STEP: iter_q <= iter_q - ITER_W'(1);
				default:                           iter_q <= iter_q;
			endcase
		end
	end

	// Shift-add multiplier and difference.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_MULA_LD: begin
				acc_q   <= '0;
				mcand_q <= PROD_W'(sq_q);
				mlr_q   <= MAG_W'(cnt_q);
			end
			OP_MULB_LD: begin
				a_q     <= acc_q;
				acc_q   <= '0;
				mcand_q <= PROD_W'(mag);
				mlr_q   <= mag;
			end
			OP_MUL_STEP: begin
				if (mlr_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q <= {mcand_q[PROD_W-2:0], 1'b0};
				mlr_q   <= {1'b0, mlr_q[MAG_W-1:1]};
			end
			OP_DIFF: begin
				diff_q <= (a_q >= acc_q) ? (a_q - acc_q) : '0;
			end
			default: begin
			end
		endcase
	end

	// Divider: variance, then mean, then variance over count.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_DIFF: begin
				divisor_q <= n_prod;
			end
			OP_VDIV_LD: begin
				sat_q <= (REM_W'(diff_q[PROD_W-1:VAR_W]) >= REM_W'(divisor_q));
				rem_q <= REM_W'(diff_q[PROD_W-1:VAR_W]);
				dvd_q <= {diff_q[VAR_W-1:0], {(PROD_W-VAR_W){1'b0}}};
			end
			OP_MDIV_LD: begin
				var_q     <= sat_q ? VAR_MAX : dvd_q[VAR_W-1:0];
				rem_q     <= '0;
				dvd_q     <= {mag, {(PROD_W-MAG_W){1'b0}}};
				divisor_q <= DIVR_W'(cnt_q);
			end
			OP_SEDIV_LD: begin
				mean_q <= sum_q[SUM_W-1] ? -$signed(quot_lo) : $signed(quot_lo);
				rem_q  <= '0;
				dvd_q  <= {var_q, {(PROD_W-VAR_W){1'b0}}};
			end
			OP_DIV_STEP: begin
				rem_q <= q_bit ? (rem_sh - REM_W'(divisor_q)) : rem_sh;
				dvd_q <= {dvd_q[PROD_W-2:0], q_bit};
			end
			default: begin
			end
		endcase
	end

	// Square root unit and result register.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_SQ1_LD: begin
				se_arg_q <= dvd_q[VAR_W-1:0];
				rad_q    <= var_q;
				root_q   <= '0;
				bit_q    <= {1'b1, {(VAR_W-1){1'b0}}};
			end
			OP_SQ2_LD: begin
				sd_q   <= root_q[RES_W-1:0];
				rad_q  <= se_arg_q;
				root_q <= '0;
				bit_q  <= {1'b1, {(VAR_W-1){1'b0}}};
			end
			OP_SQRT_STEP: begin
				if (ROOT_W'(rad_q) >= trial) begin
					rad_q  <= rad_q - trial[VAR_W-1:0];
					root_q <= (root_q >> 1) + ROOT_W'(bit_q);
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_RESULT: begin
				result.count            <= cnt_q;
				result.mean             <= mean_q;
				result.variance         <= invalid ? '0 : var_q;
				result.std_dev          <= invalid ? '0 : sd_q;
				result.std_err_mean     <= invalid ? '0 : root_q[RES_W-1:0];
				result.variance_invalid <= invalid;
				result.overflow         <= ovf_q;
			end
			default: begin
			end
		endcase
	end

endmodule

[hdl/rmv_ctrl.sv]
// Controller: sequences one item through the datapath and runs both handshakes.
// Depends on rmv_pkg for the command and status types.
`timescale 1ns / 1ps

module rmv_ctrl import rmv_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output cmd_t    cmd,
	input  status_t status
);

	typedef enum logic [4:0] {
		S_IDLE, S_MULA_LD, S_MULA, S_MULB_LD, S_MULB, S_DIFF,
		S_VDIV_LD, S_VDIV, S_MDIV_LD, S_MDIV, S_SEDIV_LD, S_SEDIV,
		S_SQ1_LD, S_SQ1, S_SQ2_LD, S_SQ2, S_DONE
	} state_t;

	state_t state_q;
	logic   out_free;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid || out_ready;

	// Operation issued in each state.
	always_comb begin
		unique case (state_q)
			S_IDLE:     cmd.op = in_valid ? OP_UPDATE : OP_NONE;
			S_MULA_LD:  cmd.op = OP_MULA_LD;
			S_MULB_LD:  cmd.op = OP_MULB_LD;
			S_MULA, S_MULB: cmd.op = OP_MUL_STEP;
			S_DIFF:     cmd.op = OP_DIFF;
			S_VDIV_LD:  cmd.op = OP_VDIV_LD;
			S_MDIV_LD:  cmd.op = OP_MDIV_LD;
			S_SEDIV_LD: cmd.op = OP_SEDIV_LD;
			S_VDIV, S_MDIV, S_SEDIV: cmd.op = OP_DIV_STEP;
			S_SQ1_LD:   cmd.op = OP_SQ1_LD;
			S_SQ2_LD:   cmd.op = OP_SQ2_LD;
			S_SQ1, S_SQ2: cmd.op = OP_SQRT_STEP;
			S_DONE:     cmd.op = out_free ? OP_RESULT : OP_NONE;
			default:    cmd.op = OP_NONE;
		endcase
	end

	// State register and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			// A finished item loads the output; an accepted result clears it.
			if (state_q == S_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:     if (in_valid) state_q <= S_MULA_LD;
				S_MULA_LD:  state_q <= S_MULA;
				S_MULA:     if (status.last) state_q <= S_MULB_LD;
				S_MULB_LD:  state_q <= S_MULB;
				S_MULB:     if (status.last) state_q <= S_DIFF;
				S_DIFF:     state_q <= S_VDIV_LD;
				S_VDIV_LD:  state_q <= S_VDIV;
				S_VDIV:     if (status.last) state_q <= S_MDIV_LD;
				S_MDIV_LD:  state_q <= S_MDIV;
				S_MDIV:     if (status.last) state_q <= S_SEDIV_LD;
				S_SEDIV_LD: state_q <= S_SEDIV;
				S_SEDIV:    if (status.last) state_q <= S_SQ1_LD;
				S_SQ1_LD:   state_q <= S_SQ1;
				S_SQ1:      if (status.last) state_q <= S_SQ2_LD;
				S_SQ2_LD:   state_q <= S_SQ2;
				S_SQ2:      if (status.last) state_q <= S_DONE;
				S_DONE:     if (out_free) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hdl/running_mean_variance.sv]
// Channel   | Dir | Payload                                         | Handshake
// in_ch     | in  | sample, restart                                 | valid/ready
// out_ch    | out | count, mean, variance, std_dev, std_err_mean... | valid/ready
// cfg       | in  | bessel_mode                                     | valid/ready
//
// After acceptance, an item passes through the serial multiplier (two products), the
// restoring divider (variance, mean, then variance over count), the square root unit
// (two roots) and the load, difference and result states before the input is ready again.
// The result becomes valid as the controller returns to idle.
// Reset clears the count, the sums and the Bessel mode register.
// The next item is taken while a result waits; a stalled result holds the controller
// at its final state until the output register frees up.
// Depends on rmv_pkg, rmv_if, rmv_ctrl and rmv_dp.
`timescale 1ns / 1ps

module running_mean_variance import rmv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rmv_in_if.sink    in_ch,
	rmv_out_if.source out_ch,
	rmv_cfg_if.sink   cfg
);

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	rmv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Arithmetic.
	rmv_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.in_item (in_ch.data),
		.cfg     (cfg),
		.result  (out_ch.data)
	);

endmodule

[dv/tb_running_mean_variance.sv]
// Testbench for running_mean_variance: directed table and random samples under
// random idling on both channels, every result checked against a table entry or an in-bench predictor.
// Depends on rmv_pkg, rmv_if and the running_mean_variance RTL.
`timescale 1ns / 1ps

module tb_running_mean_variance;
	import rmv_pkg::*;

	// One row of the directed stimulus table.
	typedef struct {
		bit          bes;
		logic [15:0] smp;
		bit          rst;
		bit          typed;
		out_item_t   exp_res;
	} dir_row_t;

	logic clk;
	logic arst_n;

	rmv_in_if  in_ch ();
	rmv_out_if out_ch ();
	rmv_cfg_if cfg ();

	running_mean_variance DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	// Predictor state and the store of expected statistics.
	bit [63:0]      acc_count;
	longint         acc_sum;
	bit [63:0]      acc_sum_sq;
	bit             bessel_q;
	out_item_t      stats_q[$];
	int             mismatch_cnt;
	int             tx_idle_pct;
	int             rx_idle_pct;
	dir_row_t       dir_rows[13];

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit.
	initial begin
		#20000000;
		$display("FAILED: results differ");
		$finish;
	end

	// Floor of the square root, one result bit at a time.
	function automatic bit [63:0] floor_sqrt(bit [63:0] v);
		bit [63:0] root;
		bit [63:0] trial;
		root = 0;
		for (int i = 31; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// Update the accumulators with one sample and work out the statistics.
	function automatic out_item_t update_stats(logic [15:0] smp, bit rst);
		out_item_t  r;
		longint     s;
		bit [127:0] lhs, rhs, diff, div, quo;
		bit [63:0]  mag, var_v;
		s = longint'($signed(smp));
		r = '0;
		if (rst) begin
			acc_count = 0;
			acc_sum = 0;
			acc_sum_sq = 0;
		end
		if (acc_count >= (64'd1 << COUNT_BITS)) begin
			r.overflow = 1'b1;
		end else begin
			acc_sum += s;
			acc_sum_sq += 64'(s * s);
			acc_count++;
		end
		r.count = acc_count[CNT_W-1:0];
		if (acc_count != 0) begin
			r.mean = 16'(acc_sum / longint'(acc_count));
			if (bessel_q && acc_count == 1) begin
				r.variance_invalid = 1'b1;
			end else begin
				mag = acc_sum < 0 ? 64'(-acc_sum) : 64'(acc_sum);
				lhs = 128'(acc_count) * 128'(acc_sum_sq);
				rhs = 128'(mag) * 128'(mag);
				diff = lhs < rhs ? 128'd0 : lhs - rhs;
				div = bessel_q ? 128'(acc_count) * 128'(acc_count - 1)
					: 128'(acc_count) * 128'(acc_count);
				quo = diff / div;
				var_v = quo > 128'(VAR_MAX) ? 64'(VAR_MAX) : quo[63:0];
				r.variance = var_v[VAR_W-1:0];
				r.std_dev = 16'(floor_sqrt(var_v));
				r.std_err_mean = 16'(floor_sqrt(var_v / acc_count));
			end
		end
		return r;
	endfunction

	// Offer one sample; returns at the falling edge after it was accepted.
	task automatic send_sample(logic [15:0] smp, bit rst, bit typed, out_item_t typed_res);
		out_item_t pred;
		if ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(12, 1)) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data.sample = smp;
		in_ch.data.restart = rst;
		do @(posedge clk); while (!in_ch.ready);
		pred = update_stats(smp, rst);
		stats_q.push_back(typed ? typed_res : pred);
		@(negedge clk);
	endtask

	// Wait until the block is idle.
	task automatic drain();
		in_ch.valid = 1'b0;
		wait (stats_q.size() == 0);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	// Write the Bessel mode register; the block must be idle.
	task automatic write_bessel(bit b);
		cfg.valid = 1'b1;
		cfg.data = b;
		do @(posedge clk); while (!cfg.ready);
		bessel_q = b;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// Receiver: random ready at the falling edge.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready = $urandom_range(99) >= rx_idle_pct;
		end
	end

	// Checker: compare each result with the oldest expectation.
	initial begin
		out_item_t e, a;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				a = out_ch.data;
				if (stats_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("Unexpected result item: %p", a);
				end else begin
					e = stats_q.pop_front();
					if (a.count !== e.count || a.mean !== e.mean
						|| a.variance !== e.variance || a.std_dev !== e.std_dev
						|| a.std_err_mean !== e.std_err_mean
						|| a.variance_invalid !== e.variance_invalid
						|| a.overflow !== e.overflow) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("Mismatch: expected %p, actual %p", e, a);
					end
				end
			end
		end
	end

	// Stimulus.
	initial begin
		logic [15:0] smp;
		bit          rst;
		acc_count = 0;
		acc_sum = 0;
		acc_sum_sq = 0;
		bessel_q = 1'b0;
		mismatch_cnt = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg.valid = 1'b0;
		cfg.data = 1'b0;
		arst_n = 1'b0;

		// Directed rows: extremes after restart, mixed values, single samples in Bessel mode.
		dir_rows = '{
			'{0, 16'h0000, 1, 1, '{21'd1, 16'h0000, 31'd0, 16'd0, 16'd0, 1'b0, 1'b0}},
			'{0, 16'h7FFF, 1, 1, '{21'd1, 16'h7FFF, 31'd0, 16'd0, 16'd0, 1'b0, 1'b0}},
			'{0, 16'h8000, 1, 1, '{21'd1, 16'h8000, 31'd0, 16'd0, 16'd0, 1'b0, 1'b0}},
			'{0, 16'h7FFF, 0, 0, '0},
			'{0, 16'h0001, 0, 0, '0},
			'{0, 16'hFFFF, 0, 0, '0},
			'{0, 16'h5555, 0, 0, '0},
			'{0, 16'hAAAA, 0, 0, '0},
			'{1, 16'h0064, 1, 1, '{21'd1, 16'h0064, 31'd0, 16'd0, 16'd0, 1'b1, 1'b0}},
			'{1, 16'h8000, 1, 1, '{21'd1, 16'h8000, 31'd0, 16'd0, 16'd0, 1'b1, 1'b0}},
			'{1, 16'h7FFF, 0, 0, '0},
			'{1, 16'h0000, 0, 0, '0},
			'{1, 16'h7FFF, 0, 0, '0}
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_bessel(1'b0);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].bes != bessel_q) begin
				drain();
				write_bessel(dir_rows[i].bes);
			end
			send_sample(dir_rows[i].smp, dir_rows[i].rst, dir_rows[i].typed,
				dir_rows[i].exp_res);
		end

		// Random phases: sender mostly busy, then receiver mostly busy, then no idling.
		for (int ph = 0; ph < 3; ph++) begin
			drain();
			write_bessel(ph != 1);
			tx_idle_pct = ph == 0 ? 7 : (ph == 1 ? 85 : 0);
			rx_idle_pct = ph == 0 ? 85 : (ph == 1 ? 7 : 0);
			for (int k = 0; k < 165; k++) begin
				case ($urandom_range(9))
					0: smp = 16'h7FFF;
					1: smp = 16'h8000;
					default: smp = 16'($urandom_range(16'hFFFF));
				endcase
				rst = k == 0 || $urandom_range(24) == 0;
				send_sample(smp, rst, 1'b0, '0);
			end
		end

		drain();
		repeat (250) @(posedge clk);
		if (stats_q.size() != 0)
			mismatch_cnt++;
		if (mismatch_cnt == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
